// ===== rtl/aip_pkg.sv =====
package aip_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARCHIVE_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_LIMIT    = 1'b1;

    localparam logic [31:0] ENTRY_LIMIT_RESET = 32'd200000;

    // result word kinds
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_OK    = 2'd2;
    localparam logic [1:0] KIND_FAIL  = 2'd3;

    // UTF-8 encoding
    localparam logic [15:0] UTF_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF_CONT      = 8'h80;
    localparam logic [7:0]  UTF_MASK      = 8'h3F;

    // command from front to back
    typedef enum logic [1:0] {
        CMD_UNIT,
        CMD_ENTRY,
        CMD_FINISH
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic        fin;     // entry closes the archive
        logic        ok;      // final verdict
        logic [15:0] unit;
        logic [31:0] size;
        logic [31:0] offset;
        logic [31:0] number;
    } t_cmd;

endpackage

// ===== rtl/archive_index_parser_core.sv =====
// Archive index parser. Bytes of an archive go in one word per push; first_byte
// restarts parsing, and after reset the next byte is taken as byte 0 anyway.
// The header is a little-endian entry count and index size (index end is 8
// plus the size); each entry is size, offset and a zero-terminated UTF-16LE
// name. Out come name bytes as UTF-8 (kind 0, no surrogate pairing), one word
// per finished entry (kind 1) and a closing success (2) or failure (3) word,
// after which bytes are swallowed until the next first_byte. o_last marks the
// final word caused by one input byte. Rate: the front takes one byte per
// cycle while the queue has room and turns it into at most one command; the
// back issues one result word per cycle while the output is not stalled. A byte
// yields at most 3 words; an entry that closes the archive yields 2. The
// first word of a byte passes the command queue and then the back's output
// register on its way to the outputs. The back's single output port sets the
// sustained rate; the command queue of QUEUE_DEPTH entries absorbs bursts,
// and while it is full no byte is taken, even one that would yield nothing.
// Write archive_length and entry_limit only while the block is idle.
module archive_index_parser_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte input, queue style
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_first_byte,
    // result output, queue style
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_name_byte,
    output logic [31:0]                     o_entry_size,
    output logic [31:0]                     o_entry_offset,
    output logic [31:0]                     o_entry_number,
    output logic                            o_last,
    // configuration writes
    input  logic                            i_cfg_wr_en,
    input  logic [aip_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import aip_pkg::*;

    logic accept;
    logic cmd_push, cmd_full, cmd_valid, cmd_pop, out_valid;
    t_cmd front_cmd, queue_cmd;

    // a byte is taken whenever the queue has room for its command
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // front: header and entry parsing, checks, one command per byte at most
    aip_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cmd_valid  (cmd_push),
        .o_cmd        (front_cmd)
    );

    // decoupling queue
    aip_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_rdata (queue_cmd),
        .o_valid (cmd_valid)
    );

    // back: expands commands to result words into the output register
    aip_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (queue_cmd),
        .o_cmd_pop      (cmd_pop),
        .i_pop          (pop),
        .o_out_valid    (out_valid),
        .o_kind         (o_kind),
        .o_name_byte    (o_name_byte),
        .o_entry_size   (o_entry_size),
        .o_entry_offset (o_entry_offset),
        .o_entry_number (o_entry_number),
        .o_last         (o_last)
    );

    assign empty = !out_valid;

endmodule

// ===== rtl/aip_front.sv =====
module aip_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_first_byte,
    input  logic                           i_cfg_wr_en,
    input  logic [aip_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_cmd_valid,
    output aip_pkg::t_cmd                  o_cmd
);
    import aip_pkg::*;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_ISIZE,
        PH_ESIZE,
        PH_EOFF,
        PH_NLO,
        PH_NHI,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase, ph_e;
    logic [32:0] r_pos, n_pos, pos_e;
    logic [1:0]  r_bcnt, n_bcnt, bcnt_e;
    logic [23:0] r_acc, n_acc;
    logic [31:0] r_total, n_total;
    logic [31:0] r_index_end, n_index_end;
    logic [31:0] r_seen, n_seen, seen_e, seen_inc;
    logic [31:0] r_size, n_size;
    logic [31:0] r_offset, n_offset;
    logic [7:0]  r_low, n_low;
    logic        r_nonempty, n_nonempty;
    logic [31:0] r_archive_length, r_entry_limit;
    logic [31:0] word;
    logic [32:0] isize_end;
    logic [15:0] unit;
    logic        do_fail;

    always_comb begin
        ph_e     = i_first_byte ? PH_COUNT : r_phase;
        pos_e    = i_first_byte ? 33'd0 : r_pos;
        bcnt_e   = i_first_byte ? 2'd0 : r_bcnt;
        seen_e   = i_first_byte ? 32'd0 : r_seen;
        seen_inc = seen_e + 32'd1;
        word      = {i_data_byte, r_acc};
        isize_end = {1'b0, word} + 33'd8;
        unit      = {i_data_byte, r_low};

        n_phase     = r_phase;
        n_pos       = r_pos;
        n_bcnt      = r_bcnt;
        n_acc       = r_acc;
        n_total     = r_total;
        n_index_end = r_index_end;
        n_seen      = r_seen;
        n_size      = r_size;
        n_offset    = r_offset;
        n_low       = r_low;
        n_nonempty  = r_nonempty;
        do_fail     = 1'b0;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;

        if (i_accept) begin
            n_phase = ph_e;
            n_pos   = pos_e;
            n_bcnt  = bcnt_e;
            n_seen  = seen_e;
            if (ph_e != PH_DONE) begin
                n_pos = pos_e + 33'd1;
                unique case (ph_e)
                    PH_COUNT, PH_ISIZE, PH_ESIZE, PH_EOFF: begin
                        if (ph_e == PH_ESIZE && bcnt_e == 2'd0
                                && pos_e >= {1'b0, r_index_end}) begin
                            do_fail = 1'b1;
                        end else begin
                            n_acc  = {i_data_byte, r_acc[23:8]};
                            n_bcnt = bcnt_e + 2'd1;
                            if (bcnt_e == 2'd3) begin
                                unique case (ph_e)
                                    PH_COUNT: begin
                                        n_total = word;
                                        if (word == 32'd0 || word > r_entry_limit) begin
                                            do_fail = 1'b1;
                                        end else begin
                                            n_phase = PH_ISIZE;
                                        end
                                    end
                                    PH_ISIZE: begin
                                        if (isize_end[32]
                                                || isize_end[31:0] >= r_archive_length) begin
                                            do_fail = 1'b1;
                                        end else begin
                                            n_index_end = isize_end[31:0];
                                            n_seen      = 32'd0;
                                            n_phase     = PH_ESIZE;
                                        end
                                    end
                                    PH_ESIZE: begin
                                        n_size  = word;
                                        n_phase = PH_EOFF;
                                    end
                                    default: begin
                                        n_offset   = word;
                                        n_nonempty = 1'b0;
                                        n_phase    = PH_NLO;
                                    end
                                endcase
                            end
                        end
                    end
                    PH_NLO: begin
                        if (pos_e >= {1'b0, r_index_end}) begin
                            do_fail = 1'b1;
                        end else begin
                            n_low   = i_data_byte;
                            n_phase = PH_NHI;
                        end
                    end
                    PH_NHI: begin
                        if (unit == 16'd0) begin
                            if (!r_nonempty) begin
                                do_fail = 1'b1;
                            end else begin
                                o_cmd_valid  = 1'b1;
                                o_cmd.op     = CMD_ENTRY;
                                o_cmd.size   = r_size;
                                o_cmd.offset = r_offset;
                                o_cmd.number = seen_e;
                                n_seen       = seen_inc;
                                if (seen_inc == r_total) begin
                                    o_cmd.fin = 1'b1;
                                    o_cmd.ok  = (pos_e + 33'd1 == {1'b0, r_index_end});
                                    n_phase   = PH_DONE;
                                end else begin
                                    n_phase = PH_ESIZE;
                                end
                            end
                        end else begin
                            o_cmd_valid  = 1'b1;
                            o_cmd.op     = CMD_UNIT;
                            o_cmd.unit   = unit;
                            o_cmd.number = seen_e;
                            n_nonempty   = 1'b1;
                            n_phase      = PH_NLO;
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
                if (do_fail) begin
                    o_cmd_valid  = 1'b1;
                    o_cmd        = '0;
                    o_cmd.op     = CMD_FINISH;
                    o_cmd.ok     = 1'b0;
                    o_cmd.number = seen_e;
                    n_phase      = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_COUNT;
            r_pos            <= '0;
            r_bcnt           <= '0;
            r_seen           <= '0;
            r_nonempty       <= 1'b0;
            r_archive_length <= '0;
            r_entry_limit    <= ENTRY_LIMIT_RESET;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_bcnt     <= n_bcnt;
            r_seen     <= n_seen;
            r_nonempty <= n_nonempty;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_ARCHIVE_LENGTH: r_archive_length <= i_cfg_data;
                    CFG_ENTRY_LIMIT:    r_entry_limit    <= i_cfg_data;
                    default:            ;
                endcase
            end
        end
        r_acc       <= n_acc;
        r_total     <= n_total;
        r_index_end <= n_index_end;
        r_size      <= n_size;
        r_offset    <= n_offset;
        r_low       <= n_low;
    end

endmodule

// ===== rtl/aip_cmd_fifo.sv =====
module aip_cmd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  aip_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output aip_pkg::t_cmd o_rdata,
    output logic          o_valid
);
    import aip_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/aip_back.sv =====
module aip_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  aip_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_out_valid,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_name_byte,
    output logic [31:0]   o_entry_size,
    output logic [31:0]   o_entry_offset,
    output logic [31:0]   o_entry_number,
    output logic          o_last
);
    import aip_pkg::*;

    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_name_byte;
    logic [31:0] r_size, r_offset, r_number;
    logic        r_last;

    logic [1:0]  n_units;
    logic [7:0]  lead2, lead3, mid, tail;
    logic [1:0]  res_kind;
    logic [7:0]  res_byte;
    logic [31:0] res_size, res_offset, res_number;
    logic        res_last;
    logic        advance;

    always_comb begin
        if (i_cmd.unit < UTF_ONE_LIMIT) begin
            n_units = 2'd1;
        end else if (i_cmd.unit < UTF_TWO_LIMIT) begin
            n_units = 2'd2;
        end else begin
            n_units = 2'd3;
        end
        lead2 = UTF_LEAD2 | {3'b0, i_cmd.unit[10:6]};
        lead3 = UTF_LEAD3 | {4'b0, i_cmd.unit[15:12]};
        mid   = UTF_CONT | ({2'b0, i_cmd.unit[11:6]} & UTF_MASK);
        tail  = UTF_CONT | ({2'b0, i_cmd.unit[5:0]} & UTF_MASK);

        res_kind   = KIND_FAIL;
        res_byte   = '0;
        res_size   = '0;
        res_offset = '0;
        res_number = i_cmd.number;
        res_last   = 1'b1;

        unique case (i_cmd.op)
            CMD_UNIT: begin
                res_kind = KIND_NAME;
                res_last = (r_idx == n_units - 2'd1);
                if (r_idx == 2'd0) begin
                    if (n_units == 2'd1) begin
                        res_byte = i_cmd.unit[7:0];
                    end else if (n_units == 2'd2) begin
                        res_byte = lead2;
                    end else begin
                        res_byte = lead3;
                    end
                end else if (r_idx == 2'd1 && n_units == 2'd3) begin
                    res_byte = mid;
                end else begin
                    res_byte = tail;
                end
            end
            CMD_ENTRY: begin
                if (r_idx == 2'd0) begin
                    res_kind   = KIND_ENTRY;
                    res_size   = i_cmd.size;
                    res_offset = i_cmd.offset;
                    res_last   = !i_cmd.fin;
                end else begin
                    res_kind   = i_cmd.ok ? KIND_OK : KIND_FAIL;
                    res_number = i_cmd.number + 32'd1;
                end
            end
            CMD_FINISH: begin
                res_kind = i_cmd.ok ? KIND_OK : KIND_FAIL;
            end
            default: begin
                res_kind = KIND_FAIL;
            end
        endcase
    end

    assign advance   = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = advance && res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_idx       <= res_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_kind      <= res_kind;
            r_name_byte <= res_byte;
            r_size      <= res_size;
            r_offset    <= res_offset;
            r_number    <= res_number;
            r_last      <= res_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_name_byte    = r_name_byte;
    assign o_entry_size   = r_size;
    assign o_entry_offset = r_offset;
    assign o_entry_number = r_number;
    assign o_last         = r_last;

endmodule

// ===== rtl/aip_checker.sv =====
module aip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_name_byte,
    input logic [31:0] o_entry_size,
    input logic [31:0] o_entry_offset,
    input logic [31:0] o_entry_number,
    input logic        o_last
);
    import aip_pkg::*;

    // a waiting word holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kind) && $stable(o_name_byte)
            && $stable(o_entry_number) && $stable(o_last))
        else $error("result word changed while stalled");

    // a verdict always closes the byte's words
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_kind == KIND_OK || o_kind == KIND_FAIL) |-> o_last)
        else $error("verdict word not marked last");

    // only entry words carry size and offset
    a_entry_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind != KIND_ENTRY |-> o_entry_size == 32'd0 && o_entry_offset == 32'd0)
        else $error("size or offset on a non-entry word");

    // only name words carry a byte
    a_name_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind != KIND_NAME |-> o_name_byte == 8'd0)
        else $error("name byte on a non-name word");

endmodule

bind archive_index_parser_core aip_checker u_aip_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_kind         (o_kind),
    .o_name_byte    (o_name_byte),
    .o_entry_size   (o_entry_size),
    .o_entry_offset (o_entry_offset),
    .o_entry_number (o_entry_number),
    .o_last         (o_last)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aip_pkg::*;

    // run bounds
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_PAD    = 24;   // queue depth plus pipeline, with margin
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned RANDOM_BYTES = 12;   // minimum parsed bytes per random phase
    localparam int unsigned MAX_REPORTS  = 10;

    // parser phases, mirrored for the local model
    typedef enum logic [2:0] {
        PS_COUNT,
        PS_ISIZE,
        PS_ESIZE,
        PS_EOFF,
        PS_NLO,
        PS_NHI,
        PS_DONE
    } t_parse_phase;

    // flavours of UTF-16 name unit
    typedef enum int {
        UC_ASCII,
        UC_TWO,
        UC_THREE,
        UC_SURR,
        UC_EDGE,
        UC_ANY
    } t_unit_class;

    // one result word as seen on the output ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_byte;
        logic [31:0] size;
        logic [31:0] offset;
        logic [31:0] number;
        logic        last;
    } t_index_word;

    // ---------------------------------------------------------------
    // clock, DUT ports
    // ---------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             i_data_byte = 8'h00;
    logic                   i_first_byte = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [1:0]             o_kind;
    logic [7:0]             o_name_byte;
    logic [31:0]            o_entry_size;
    logic [31:0]            o_entry_offset;
    logic [31:0]            o_entry_number;
    logic                   o_last;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_ARCHIVE_LENGTH;
    logic [31:0]            i_cfg_data = 32'd0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    archive_index_parser_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_name_byte    (o_name_byte),
        .o_entry_size   (o_entry_size),
        .o_entry_offset (o_entry_offset),
        .o_entry_number (o_entry_number),
        .o_last         (o_last),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // local copy of the parser: registers and state
    // ---------------------------------------------------------------
    logic [31:0]  cfg_length = 32'd0;
    logic [31:0]  cfg_limit  = ENTRY_LIMIT_RESET;

    t_parse_phase ps_phase;
    logic [32:0]  ps_pos;
    logic [5:0]   ps_shift;
    logic [31:0]  ps_acc;
    logic [31:0]  ps_total;
    logic [32:0]  ps_end;
    logic [31:0]  ps_seen;
    logic [31:0]  ps_size;
    logic [31:0]  ps_offset;
    logic [7:0]   ps_low;
    logic         ps_named;

    // words of the current byte, flagged last once the byte is done
    t_index_word  byte_words[0:2];
    int           byte_word_cnt;

    t_index_word  index_words[$];      // words still owed by the DUT
    int unsigned  parsed_bytes = 0;    // bytes the parser actually consumed
    int unsigned  bad_words = 0;

    // stimulus knobs
    int           send_idle_pct = 26;
    int           recv_idle_pct = 74;
    logic         hold_pop = 1'b0;

    // archive under construction
    logic [7:0]   image_bytes[$];

    function automatic void restart_parse();
        ps_phase  = PS_COUNT;
        ps_pos    = '0;
        ps_shift  = '0;
        ps_acc    = '0;
        ps_total  = '0;
        ps_end    = '0;
        ps_seen   = '0;
        ps_size   = '0;
        ps_offset = '0;
        ps_low    = '0;
        ps_named  = 1'b0;
    endfunction

    function automatic void add_word(input logic [1:0] kind, input logic [7:0] nb,
                                     input logic [31:0] sz, input logic [31:0] off);
        t_index_word w;
        w.kind      = kind;
        w.name_byte = nb;
        w.size      = sz;
        w.offset    = off;
        w.number    = ps_seen;
        w.last      = 1'b0;
        if (byte_word_cnt < 3) begin
            byte_words[byte_word_cnt] = w;
            byte_word_cnt++;
        end
    endfunction

    function automatic void close_parse(input logic [1:0] kind);
        add_word(kind, 8'h00, 32'd0, 32'd0);
        ps_phase = PS_DONE;
    endfunction

    // a full little-endian header or entry field has arrived
    function automatic void field_done(input logic [31:0] w);
        logic [32:0] end_at;
        case (ps_phase)
            PS_COUNT: begin
                ps_total = w;
                if (w == 32'd0 || w > cfg_limit) close_parse(KIND_FAIL);
                else ps_phase = PS_ISIZE;
            end
            PS_ISIZE: begin
                end_at = 33'd8 + {1'b0, w};
                if (end_at[32] || end_at[31:0] >= cfg_length) begin
                    close_parse(KIND_FAIL);
                end else begin
                    ps_end   = end_at;
                    ps_seen  = '0;
                    ps_phase = PS_ESIZE;
                end
            end
            PS_ESIZE: begin
                ps_size  = w;
                ps_phase = PS_EOFF;
            end
            default: begin
                ps_offset = w;
                ps_named  = 1'b0;
                ps_phase  = PS_NLO;
            end
        endcase
    endfunction

    // a whole UTF-16 unit: terminator closes the entry, otherwise UTF-8 out
    function automatic void unit_done(input logic [15:0] c);
        if (c == 16'h0000) begin
            if (!ps_named) begin
                close_parse(KIND_FAIL);
            end else begin
                add_word(KIND_ENTRY, 8'h00, ps_size, ps_offset);
                ps_seen++;
                if (ps_seen == ps_total)
                    close_parse((ps_pos == ps_end) ? KIND_OK : KIND_FAIL);
                else
                    ps_phase = PS_ESIZE;
            end
        end else begin
            if (c < UTF_ONE_LIMIT) begin
                add_word(KIND_NAME, c[7:0], 32'd0, 32'd0);
            end else if (c < UTF_TWO_LIMIT) begin
                add_word(KIND_NAME, UTF_LEAD2 | 8'(c >> 6), 32'd0, 32'd0);
                add_word(KIND_NAME, UTF_CONT | (c[7:0] & UTF_MASK), 32'd0, 32'd0);
            end else begin
                add_word(KIND_NAME, UTF_LEAD3 | 8'(c >> 12), 32'd0, 32'd0);
                add_word(KIND_NAME, UTF_CONT | (8'(c >> 6) & UTF_MASK), 32'd0, 32'd0);
                add_word(KIND_NAME, UTF_CONT | (c[7:0] & UTF_MASK), 32'd0, 32'd0);
            end
            ps_named = 1'b1;
            ps_phase = PS_NLO;
        end
    endfunction

    // one accepted byte: advance the parser and queue the words it owes
    function automatic void parse_archive_byte(input logic [7:0] b, input logic fb);
        logic [32:0] at;
        logic [31:0] w;
        int          k;
        byte_word_cnt = 0;
        if (fb) restart_parse();
        if (ps_phase != PS_DONE) begin
            parsed_bytes++;
            at     = ps_pos;
            ps_pos = ps_pos + 33'd1;
            case (ps_phase)
                PS_COUNT, PS_ISIZE, PS_ESIZE, PS_EOFF: begin
                    if (ps_phase == PS_ESIZE && ps_shift == 6'd0 && at >= ps_end) begin
                        close_parse(KIND_FAIL);
                    end else begin
                        ps_acc   = ps_acc | ({24'd0, b} << ps_shift);
                        ps_shift = ps_shift + 6'd8;
                        if (ps_shift >= 6'd32) begin
                            w        = ps_acc;
                            ps_acc   = '0;
                            ps_shift = '0;
                            field_done(w);
                        end
                    end
                end
                PS_NLO: begin
                    if (at >= ps_end) begin
                        close_parse(KIND_FAIL);
                    end else begin
                        ps_low   = b;
                        ps_phase = PS_NHI;
                    end
                end
                PS_NHI: unit_done({b, ps_low});
                default: ps_phase = PS_DONE;
            endcase
        end
        for (k = 0; k < byte_word_cnt; k++) begin
            byte_words[k].last = (k == byte_word_cnt - 1);
            index_words.insert(index_words.size(), byte_words[k]);
        end
    endfunction

    // ---------------------------------------------------------------
    // result side: pop at random, check each popped word
    // ---------------------------------------------------------------
    function automatic void check_word();
        t_index_word want;
        if (index_words.size() == 0) begin
            bad_words++;
            if (bad_words <= MAX_REPORTS)
                $display("unexpected word: kind %0d name %h size %h offset %h number %0d last %0d",
                         o_kind, o_name_byte, o_entry_size, o_entry_offset,
                         o_entry_number, o_last);
        end else begin
            want = index_words.pop_front();
            if (o_kind !== want.kind || o_name_byte !== want.name_byte ||
                o_entry_size !== want.size || o_entry_offset !== want.offset ||
                o_entry_number !== want.number || o_last !== want.last) begin
                bad_words++;
                if (bad_words <= MAX_REPORTS) begin
                    $display("word mismatch (want/got): kind %0d/%0d name %h/%h last %0d/%0d",
                             want.kind, o_kind, want.name_byte, o_name_byte,
                             want.last, o_last);
                    $display("  size %h/%h offset %h/%h number %0d/%0d",
                             want.size, o_entry_size, want.offset, o_entry_offset,
                             want.number, o_entry_number);
                end
            end
        end
    endfunction

    // pop and empty are both read before this edge takes effect
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_word();
        if (!i_rst_n || hold_pop) pop <= 1'b0;
        else pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog
    int unsigned cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // drive helpers
    // ---------------------------------------------------------------
    // offer one byte, with random gaps first; push stays high on return
    task automatic send_byte(input logic [7:0] b, input logic fb);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= fb;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_archive_byte(b, fb);
    endtask

    // stop offering, wait for every owed word, then let the pipe empty out
    // (a byte may be mid-flight with nothing owed)
    task automatic settle();
        push <= 1'b0;
        while (index_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_ARCHIVE_LENGTH) cfg_length = val;
        else cfg_limit = val;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // archive image builders
    // ---------------------------------------------------------------
    function automatic void append_byte(input logic [7:0] b);
        image_bytes.insert(image_bytes.size(), b);
    endfunction

    function automatic void add_le32(input logic [31:0] w);
        append_byte(w[7:0]);
        append_byte(w[15:8]);
        append_byte(w[23:16]);
        append_byte(w[31:24]);
    endfunction

    function automatic void set_word(input int at, input logic [31:0] w);
        image_bytes[at]     = w[7:0];
        image_bytes[at + 1] = w[15:8];
        image_bytes[at + 2] = w[23:16];
        image_bytes[at + 3] = w[31:24];
    endfunction

    function automatic void start_image(input logic [31:0] count, input logic [31:0] isize);
        image_bytes.delete();
        add_le32(count);
        add_le32(isize);
    endfunction

    function automatic void add_unit(input logic [15:0] u);
        append_byte(u[7:0]);
        append_byte(u[15:8]);
    endfunction

    // index size that makes the index end exactly at the end of the image
    function automatic void fit_index();
        set_word(4, 32'(image_bytes.size() - 8));
    endfunction

    function automatic void trim_image(input int keep);
        while (image_bytes.size() > keep) void'(image_bytes.pop_back());
    endfunction

    function automatic logic [15:0] random_unit(input t_unit_class cls);
        t_unit_class c;
        logic [15:0] u;
        c = (cls == UC_ANY) ? t_unit_class'($urandom_range(0, 4)) : cls;
        case (c)
            UC_ASCII: u = 16'($urandom_range(1, 16'h007F));
            UC_TWO:   u = 16'($urandom_range(16'h0080, 16'h07FF));
            UC_THREE: u = 16'($urandom_range(16'h0800, 16'hFFFF));
            UC_SURR:  u = 16'($urandom_range(16'hD800, 16'hDFFF));
            default: begin
                case ($urandom_range(0, 7))
                    0: u = 16'h0001;
                    1: u = 16'h007F;
                    2: u = 16'h0080;
                    3: u = 16'h07FF;
                    4: u = 16'h0800;
                    5: u = 16'hFFFF;
                    6: u = 16'h0100;   // zero low byte, still a real unit
                    default: u = 16'h8000;
                endcase
            end
        endcase
        return u;
    endfunction

    // size, offset, name of n units and its terminator (n = 0: empty name)
    function automatic void add_random_entry(input int n, input t_unit_class cls);
        int k;
        add_le32($urandom);
        add_le32($urandom);
        for (k = 0; k < n; k++) add_unit(random_unit(cls));
        add_unit(16'h0000);
    endfunction

    task automatic send_image(input logic mark);
        int k;
        for (k = 0; k < image_bytes.size(); k++)
            send_byte(image_bytes[k], mark && (k == 0));
    endtask

    // one random archive: mostly well formed, the rest broken or plain noise
    task automatic random_archive();
        int roll;
        int n;
        int e;
        int hole;
        int cut;
        logic [31:0] fit;
        roll = $urandom_range(0, 99);
        if (roll >= 95) begin
            // noise, with the odd restart marker thrown in
            repeat ($urandom_range(4, 16))
                send_byte(8'($urandom), $urandom_range(0, 5) == 0);
        end else begin
            n    = $urandom_range(1, 3);
            hole = $urandom_range(0, n - 1);
            start_image(n, 0);
            for (e = 0; e < n; e++)
                add_random_entry((roll >= 85 && roll < 89 && e == hole) ? 0 :
                                 $urandom_range(1, 4), UC_ANY);
            fit = 32'(image_bytes.size() - 8);
            set_word(4, fit);
            if (roll < 60) begin
                // trailing bytes are swallowed once the verdict is out
                repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
            end else if (roll < 65) begin
                set_word(0, 32'd0);
            end else if (roll < 69) begin
                set_word(0, (cfg_limit == 32'hFFFF_FFFF) ? 32'd0 : cfg_limit + 32'd1);
            end else if (roll < 73) begin
                set_word(4, 32'hFFFF_FFF8 + 32'($urandom_range(0, 7)));
            end else if (roll < 77) begin
                set_word(4, (cfg_length >= 32'd8) ?
                         cfg_length - 32'd8 + 32'($urandom_range(0, 3)) : 32'($urandom));
            end else if (roll < 81) begin
                set_word(4, fit - 32'($urandom_range(1, 10)));
            end else if (roll < 85) begin
                set_word(4, fit + 32'($urandom_range(1, 10)));
            end else if (roll >= 89) begin
                // cut short; the next archive restarts mid-parse
                cut = $urandom_range(1, image_bytes.size() - 1);
                trim_image(cut);
            end
            if ($urandom_range(0, 9) == 0) settle();
            send_image(1'b1);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // reset values: length 0 and limit 200000; first archive carries no marker
    task automatic test_reset_state();
        start_image(ENTRY_LIMIT_RESET, 32'd0);
        send_image(1'b0);                 // limit itself is fine, end 8 >= 0 is not
        start_image(ENTRY_LIMIT_RESET + 32'd1, 32'd0);
        trim_image(4);
        send_image(1'b1);                 // one over the limit
        send_byte(8'hFF, 1'b0);           // swallowed
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_header_checks();
        settle();
        write_reg(CFG_ARCHIVE_LENGTH, 32'hFFFF_FFFF);
        write_reg(CFG_ENTRY_LIMIT, 32'd1);
        start_image(32'd0, 32'd0);
        trim_image(4);
        send_image(1'b1);                 // zero count
        start_image(32'd2, 32'd0);
        trim_image(4);
        send_image(1'b1);                 // above limit
        start_image(32'd1, 32'hFFFF_FFF8);
        send_image(1'b1);                 // index end wraps
        start_image(32'd1, 32'hFFFF_FFF7);
        send_image(1'b1);                 // index end equals the length
        start_image(32'd1, 32'hFFFF_FFF6);
        append_byte(8'hAA);
        append_byte(8'h55);
        append_byte(8'h00);
        send_image(1'b1);                 // header passes, cut mid entry
    endtask

    task automatic test_name_checks();
        // every UTF-8 length at its edges, plus a lone surrogate
        start_image(32'd1, 32'd0);
        add_le32(32'hFFFF_FFFF);
        add_le32(32'h0000_0000);
        add_unit(16'h0001);
        add_unit(16'h007F);
        add_unit(16'h0080);
        add_unit(16'h07FF);
        add_unit(16'h0800);
        add_unit(16'hFFFF);
        add_unit(16'hD800);
        add_unit(16'h0100);
        add_unit(16'h0000);
        fit_index();
        append_byte(8'h12);
        send_image(1'b1);
        // empty name
        start_image(32'd1, 32'd0);
        add_random_entry(0, UC_ASCII);
        fit_index();
        send_image(1'b1);
        // second unit sits on the index end
        start_image(32'd1, 32'd10);
        add_random_entry(2, UC_ASCII);
        send_image(1'b1);
        // index end beyond the last terminator
        start_image(32'd1, 32'd0);
        add_random_entry(2, UC_TWO);
        set_word(4, 32'(image_bytes.size() - 8 + 2));
        send_image(1'b1);
    endtask

    task automatic test_entry_bounds();
        settle();
        write_reg(CFG_ENTRY_LIMIT, 32'hFFFF_FFFF);
        // index ends where the second entry's size starts
        start_image(32'd2, 32'd0);
        add_random_entry(2, UC_ASCII);
        fit_index();
        add_random_entry(1, UC_TWO);
        send_image(1'b1);
        // two entries, exact fit
        start_image(32'd2, 32'd0);
        add_random_entry(1, UC_TWO);
        add_random_entry(2, UC_THREE);
        fit_index();
        send_image(1'b1);
    endtask

    // receiver holds off while the sender keeps going, so the block backs up
    task automatic test_output_stall();
        int e;
        send_idle_pct = 0;
        start_image(32'd2, 32'd0);
        for (e = 0; e < 2; e++) add_random_entry(4, UC_THREE);
        fit_index();
        fork
            begin
                hold_pop <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pop <= 1'b0;
            end
            send_image(1'b1);
        join
        settle();
    endtask

    task automatic test_random_mix(input int tx_idle, input int rx_idle,
                                   input logic [31:0] length, input logic [31:0] limit);
        int unsigned from;
        settle();
        write_reg(CFG_ARCHIVE_LENGTH, length);
        write_reg(CFG_ENTRY_LIMIT, limit);
        send_idle_pct = tx_idle;
        recv_idle_pct <= rx_idle;
        from = parsed_bytes;
        while (parsed_bytes - from < RANDOM_BYTES) random_archive();
    endtask

    initial begin
        restart_parse();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_header_checks();
        test_name_checks();
        test_entry_bounds();
        test_output_stall();
        // sender idles a quarter of the time, receiver three quarters; then swapped, then neither idles
        test_random_mix(26, 74, 32'hFFFF_FFFF, ENTRY_LIMIT_RESET);
        test_random_mix(74, 26, 32'($urandom_range(40, 160)), 32'd3);
        test_random_mix(0, 0, 32'($urandom_range(1000, 32'hFFFF_FFFE)), 32'hFFFF_FFFF);

        settle();
        if (bad_words == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== archive_index_parser_core.f =====
rtl/aip_pkg.sv
rtl/aip_front.sv
rtl/aip_cmd_fifo.sv
rtl/aip_back.sv
rtl/archive_index_parser_core.sv
rtl/aip_checker.sv
tb/sv/tb_top.sv
